/* hw/rtl/rlt_pkg.sv */
// rlt_pkg: shared types and constants for the range lock table.
// Holds the beat structs, opcodes and the token handed from cell to cell.
// No dependencies.
`default_nettype none

package rlt_pkg;

  localparam int unsigned TABLE_ENTRIES_DEF = 64;

  localparam int unsigned START_W = 48;
  localparam int unsigned SIZE_W  = 32;
  localparam int unsigned TXN_W   = 31;
  localparam int unsigned COUNT_W = 7;
  // range end: one carry bit plus one sign bit beyond the start width
  localparam int unsigned LAST_W  = START_W + 2;

  localparam logic [1:0] OP_LOCK     = 2'd0;
  localparam logic [1:0] OP_RELEASE  = 2'd1;
  localparam logic [1:0] OP_QUERY    = 2'd2;
  localparam logic [1:0] OP_ROLLBACK = 2'd3;

  typedef struct packed {
    logic [1:0]         opcode;
    logic [START_W-1:0] range_start;
    logic [SIZE_W-1:0]  range_size;
    logic [TXN_W-1:0]   txn_id;
  } req_t;

  typedef struct packed {
    logic               status;
    logic               overlap_found;
    logic [COUNT_W-1:0] cleared_count;
    logic [COUNT_W-1:0] used_count;
  } rsp_t;

  // request as it walks down the chain, with results gathered so far
  typedef struct packed {
    logic               valid;
    logic [1:0]         op;
    logic               want;      // lock with a nonzero size
    logic [START_W-1:0] first;
    logic [LAST_W-1:0]  last;      // two's complement, start+size-1
    logic [TXN_W-1:0]   txn;
    logic               placed;
    logic               found;
    logic [COUNT_W-1:0] cleared;
  } tok_t;

endpackage

`default_nettype wire

/* hw/rtl/rlt_cell.sv */
// rlt_cell: one table entry plus one stage of the request chain.
// Depends on rlt_pkg.
`default_nettype none

module rlt_cell (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          adv_i,
  input  wire rlt_pkg::tok_t tok_i,
  output rlt_pkg::tok_t      tok_o
);

  logic                          held_q, held_d;
  logic [rlt_pkg::START_W-1:0]   start_q;
  logic [rlt_pkg::START_W:0]     last_q;     // entry end, never negative
  logic [rlt_pkg::TXN_W-1:0]     owner_q;
  rlt_pkg::tok_t                 tok_q, tok_d;

  logic overlap, hit, place, clear;

  always_comb begin
    overlap = ({1'b0, tok_i.first} <= last_q) &&
              ($signed(tok_i.last) >= $signed({2'b00, start_q}));
    hit = 1'b0;
    case (tok_i.op)
      rlt_pkg::OP_RELEASE:  hit = overlap;
      rlt_pkg::OP_QUERY:    hit = overlap;
      rlt_pkg::OP_ROLLBACK: hit = (owner_q == tok_i.txn);
      default:              hit = 1'b0;
    endcase
    hit   = hit && held_q && tok_i.valid;
    place = tok_i.valid && tok_i.want && !tok_i.placed && !held_q;
    clear = hit && (tok_i.op != rlt_pkg::OP_QUERY);

    held_d = held_q;
    if (place) begin
      held_d = 1'b1;
    end else if (clear) begin
      held_d = 1'b0;
    end

    tok_d        = tok_i;
    tok_d.placed = tok_i.placed | place;
    tok_d.found  = tok_i.found | (hit && (tok_i.op == rlt_pkg::OP_QUERY));
    tok_d.cleared = tok_i.cleared + {{(rlt_pkg::COUNT_W-1){1'b0}}, clear};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      held_q <= 1'b0;
      tok_q  <= '0;
    end else if (adv_i) begin
      held_q <= held_d;
      tok_q  <= tok_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv_i && place) begin
      start_q <= tok_i.first;
      last_q  <= tok_i.last[rlt_pkg::START_W:0];
      owner_q <= tok_i.txn;
    end
  end

  assign tok_o = tok_q;

endmodule

`default_nettype wire

/* hw/rtl/range_lock_table.sv */
// range_lock_table: top level of the block-range lock table.
// Depends on rlt_pkg and rlt_cell.
//
// Usage:
//   Input channel (in_valid_i / in_stall_o / in_data_i) takes one request
//   beat: opcode, range_start, range_size, txn_id. Output channel
//   (out_valid_o / out_stall_i / out_data_o) returns exactly one result beat
//   per request, in request order.
//   The table is a row of TABLE_ENTRIES cells. Each cell owns one entry and
//   is one stage of a chain; a request visits cell 0, then cell 1 and so on,
//   one per cycle while the chain moves, and each cell applies it to its
//   entry and passes it on with the partial results (lowest free entry
//   taken, overlap seen, entries freed). Cell 0 registers the beat at the
//   accepting edge, each further cell registers it in turn, and the result
//   then passes through the output register.
//   Throughput: one request per cycle while the chain is not stalled;
//   requests follow each other down the chain, so each cell sees them in
//   order and the result matches strict one-at-a-time processing.
//   used_count is kept in one counter at the chain's end.
//   Stall: when a result is held and out_stall_i is high, the whole chain
//   freezes and in_stall_o goes high. A result waiting on an empty output
//   register does not block input.
//   Reset: all entries free, chain empty, used count zero. No clearing pass.
`default_nettype none

module range_lock_table #(
  parameter int unsigned TABLE_ENTRIES = rlt_pkg::TABLE_ENTRIES_DEF
) (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          in_valid_i,
  output logic               in_stall_o,
  input  wire rlt_pkg::req_t in_data_i,
  output logic               out_valid_o,
  input  wire logic          out_stall_i,
  output rlt_pkg::rsp_t      out_data_o
);

  localparam int unsigned PadW = rlt_pkg::LAST_W - rlt_pkg::SIZE_W;

  rlt_pkg::tok_t tok [TABLE_ENTRIES+1];
  rlt_pkg::tok_t tok_head;

  logic                        adv;
  logic                        out_valid_q;
  rlt_pkg::rsp_t               out_data_q, out_data_d;
  logic [rlt_pkg::COUNT_W-1:0] used_q, used_d;

  // chain moves whenever the output register is empty or being drained
  assign adv        = !out_valid_q || !out_stall_i;
  assign in_stall_o = !adv;

  // entry token: request end worked out once, in two's complement
  always_comb begin
    tok_head.valid   = in_valid_i;
    tok_head.op      = in_data_i.opcode;
    tok_head.want    = (in_data_i.opcode == rlt_pkg::OP_LOCK) &&
                       (in_data_i.range_size != '0);
    tok_head.first   = in_data_i.range_start;
    tok_head.last    = {2'b00, in_data_i.range_start} +
                       {{PadW{1'b0}}, in_data_i.range_size} -
                       {{(rlt_pkg::LAST_W-1){1'b0}}, 1'b1};
    tok_head.txn     = in_data_i.txn_id;
    tok_head.placed  = 1'b0;
    tok_head.found   = 1'b0;
    tok_head.cleared = '0;
  end

  assign tok[0] = tok_head;

  for (genvar g = 0; g < TABLE_ENTRIES; g++) begin : g_cell
    rlt_cell u_cell (
      .clk_i  (clk_i),
      .rst_ni (rst_ni),
      .adv_i  (adv),
      .tok_i  (tok[g]),
      .tok_o  (tok[g+1])
    );
  end

  // result formed at the chain's end; count wraps at 7 bits
  always_comb begin
    used_d = used_q
           + {{(rlt_pkg::COUNT_W-1){1'b0}}, tok[TABLE_ENTRIES].placed}
           - tok[TABLE_ENTRIES].cleared;
    out_data_d.status        = tok[TABLE_ENTRIES].want && !tok[TABLE_ENTRIES].placed;
    out_data_d.overlap_found = tok[TABLE_ENTRIES].found;
    out_data_d.cleared_count = tok[TABLE_ENTRIES].cleared;
    out_data_d.used_count    = used_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
      used_q      <= '0;
    end else if (adv) begin
      out_valid_q <= tok[TABLE_ENTRIES].valid;
      if (tok[TABLE_ENTRIES].valid) begin
        used_q <= used_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv && tok[TABLE_ENTRIES].valid) begin
      out_data_q <= out_data_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;

endmodule

`default_nettype wire

/* hw/rtl/rlt_checker.sv */
// rlt_props: port-level assertions for range_lock_table, bound to the top.
// Depends on rlt_pkg.
`default_nettype none

module rlt_props (
  input wire logic          clk_i,
  input wire logic          rst_ni,
  input wire logic          in_valid_i,
  input wire logic          in_stall_o,
  input wire rlt_pkg::req_t in_data_i,
  input wire logic          out_valid_o,
  input wire logic          out_stall_i,
  input wire rlt_pkg::rsp_t out_data_o
);

  // input is held back only by a result the receiver refuses
  a_stall_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> (out_valid_o && out_stall_i))
    else $error("input stalled without a blocked result beat");

  a_in_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && in_stall_o) |=> (in_valid_i && $stable(in_data_i)))
    else $error("stalled request beat changed");

  a_full_alone: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_data_o.status) |->
      (!out_data_o.overlap_found && out_data_o.cleared_count == '0))
    else $error("full status mixed with other results");

  a_found_alone: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_data_o.overlap_found) |-> (out_data_o.cleared_count == '0))
    else $error("query result also reports freed entries");

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_stall_i) |=> (out_valid_o && $stable(out_data_o)))
    else $error("stalled result beat changed");

endmodule

bind range_lock_table rlt_props u_rlt_props (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_valid_i),
  .in_stall_o  (in_stall_o),
  .in_data_i   (in_data_i),
  .out_valid_o (out_valid_o),
  .out_stall_i (out_stall_i),
  .out_data_o  (out_data_o)
);

`default_nettype wire

/* tb/rlt_checker.sv */
// rlt_checker: scoreboard for range_lock_table; keeps its own copy of the lock table.
// It predicts one result beat per accepted request and compares the beats in order.
// Depends on rlt_pkg.
`timescale 1ns / 100ps

module rlt_checker #(
  parameter int unsigned TABLE_ENTRIES = rlt_pkg::TABLE_ENTRIES_DEF
) (
  input  wire logic     clk_i,
  input  wire logic     rst_ni,
  input  wire logic     in_valid_i,
  input  wire logic     in_stall_i,
  input  rlt_pkg::req_t in_data_i,
  input  wire logic     out_valid_i,
  input  wire logic     out_stall_i,
  input  rlt_pkg::rsp_t out_data_i,
  output int            fail_count_o,
  output int            pending_o
);

  import rlt_pkg::*;

  localparam int REPORT_MAX = 40;

  logic [START_W-1:0] held_start [TABLE_ENTRIES];
  logic [SIZE_W-1:0]  held_size  [TABLE_ENTRIES];
  logic [TXN_W-1:0]   held_owner [TABLE_ENTRIES];
  logic [COUNT_W-1:0] held_cnt;
  rsp_t               expected_rsps [$];
  rsp_t               oldest;

  // last block of a range, signed, so an empty range ends at start-1
  function automatic longint last_block(logic [START_W-1:0] s, logic [SIZE_W-1:0] n);
    return longint'({16'd0, s}) + longint'({32'd0, n}) - 64'sd1;
  endfunction

  function automatic bit held_meets(int i, longint q_first, longint q_last);
    longint e_first;
    e_first = longint'({16'd0, held_start[i]});
    return held_size[i] != '0 && q_first <= last_block(held_start[i], held_size[i])
           && q_last >= e_first;
  endfunction

  // applies one request to the table copy and returns its result beat
  function automatic rsp_t apply_lock_req(req_t r);
    rsp_t   p;
    longint q_first;
    longint q_last;
    bit     placed;
    p       = '0;
    placed  = 1'b0;
    q_first = longint'({16'd0, r.range_start});
    q_last  = last_block(r.range_start, r.range_size);
    case (r.opcode)
      OP_LOCK: begin
        if (r.range_size != '0) begin
          for (int i = 0; i < TABLE_ENTRIES; i++) begin
            if (!placed && held_size[i] == '0) begin
              held_start[i] = r.range_start;
              held_size[i]  = r.range_size;
              held_owner[i] = r.txn_id;
              held_cnt++;
              placed = 1'b1;
            end
          end
          p.status = !placed;
        end
      end
      OP_RELEASE: begin
        for (int i = 0; i < TABLE_ENTRIES; i++) begin
          if (held_meets(i, q_first, q_last)) begin
            held_size[i] = '0;
            held_cnt--;
            p.cleared_count++;
          end
        end
      end
      OP_QUERY: begin
        for (int i = 0; i < TABLE_ENTRIES; i++) begin
          if (held_meets(i, q_first, q_last)) p.overlap_found = 1'b1;
        end
      end
      default: begin
        for (int i = 0; i < TABLE_ENTRIES; i++) begin
          if (held_size[i] != '0 && held_owner[i] == r.txn_id) begin
            held_size[i] = '0;
            held_cnt--;
            p.cleared_count++;
          end
        end
      end
    endcase
    p.used_count = held_cnt;
    return p;
  endfunction

  task automatic check_field(string name, int unsigned want, int unsigned got);
    if (want != got) begin
      if (fail_count_o < REPORT_MAX) $error("%s: expected %0d, got %0d", name, want, got);
      fail_count_o++;
    end
  endtask

  initial begin
    fail_count_o = 0;
    pending_o    = 0;
  end

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < TABLE_ENTRIES; i++) begin
        held_start[i] = '0;
        held_size[i]  = '0;
        held_owner[i] = '0;
      end
      held_cnt = '0;
      expected_rsps.delete();
    end else begin
      if (in_valid_i && !in_stall_i) expected_rsps.push_back(apply_lock_req(in_data_i));
      if (out_valid_i && !out_stall_i) begin
        if (expected_rsps.size() == 0) begin
          if (fail_count_o < REPORT_MAX) $error("result beat with no request outstanding");
          fail_count_o++;
        end else begin
          oldest = expected_rsps.pop_front();
          check_field("status", oldest.status, out_data_i.status);
          check_field("overlap_found", oldest.overlap_found, out_data_i.overlap_found);
          check_field("cleared_count", oldest.cleared_count, out_data_i.cleared_count);
          check_field("used_count", oldest.used_count, out_data_i.used_count);
        end
      end
    end
    pending_o = expected_rsps.size();
  end

endmodule

/* tb/tb_top.sv */
// tb_top: stimulus and verdict for range_lock_table, with rlt_checker beside the block.
// Directed lock/release/query/rollback beats first, then random bursts with idling.
// Depends on rlt_pkg, range_lock_table and rlt_checker.
`timescale 1ns / 100ps

module tb_top;

  import rlt_pkg::*;

  localparam int unsigned ENTRIES      = TABLE_ENTRIES_DEF;
  localparam int          RANDOM_ITEMS = 1230;
  // no-progress limit: latency plus the longest stall and gap, many times over
  localparam int          IDLE_LIMIT   = 4000;

  localparam logic [START_W-1:0] START_MAX = '1;
  localparam logic [SIZE_W-1:0]  SIZE_MAX  = '1;
  localparam logic [TXN_W-1:0]   TXN_MAX   = '1;

  typedef enum int {BURST_FILL, BURST_BLEND, BURST_DRAIN, BURST_NOISE} burst_kind_e;

  logic clk_i = 1'b0;
  logic rst_ni;
  logic in_valid;
  logic in_stall;
  req_t in_data;
  logic out_valid;
  logic out_stall;
  rsp_t out_data;
  int   fail_count;
  int   pending;

  // current burst: a window of blocks and a small pool of transactions,
  // so locks pile up in one region and releases/rollbacks actually hit
  logic [START_W-1:0] win_base;
  logic [TXN_W-1:0]   txn_pool [4];
  int                 quiet_left = 0;

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  range_lock_table #(
    .TABLE_ENTRIES(ENTRIES)
  ) i_dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid),
    .in_stall_o (in_stall),
    .in_data_i  (in_data),
    .out_valid_o(out_valid),
    .out_stall_i(out_stall),
    .out_data_o (out_data)
  );

  rlt_checker #(
    .TABLE_ENTRIES(ENTRIES)
  ) i_checker (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid),
    .in_stall_i  (in_stall),
    .in_data_i   (in_data),
    .out_valid_i (out_valid),
    .out_stall_i (out_stall),
    .out_data_i  (out_data),
    .fail_count_o(fail_count),
    .pending_o   (pending)
  );

  function automatic logic [START_W-1:0] rand_block();
    logic [63:0] w;
    w = {$urandom, $urandom};
    return w[START_W-1:0];
  endfunction

  function automatic logic [TXN_W-1:0] rand_txn();
    logic [31:0] w;
    w = $urandom;
    return w[TXN_W-1:0];
  endfunction

  function automatic req_t mk_req(logic [1:0] op, logic [START_W-1:0] s,
                                  logic [SIZE_W-1:0] n, logic [TXN_W-1:0] t);
    req_t r;
    r.opcode      = op;
    r.range_start = s;
    r.range_size  = n;
    r.txn_id      = t;
    return r;
  endfunction

  // idle cycles after a beat: mostly none, a few long; now and then a
  // stretch of back-to-back beats
  function automatic int pick_gap();
    int r;
    if (quiet_left > 0) begin
      quiet_left--;
      return 0;
    end
    r = $urandom_range(0, 99);
    if (r < 2) quiet_left = $urandom_range(50, 150);
    if (r < 60) return 0;
    if (r < 90) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 80);
  endfunction

  // valid goes up at the falling edge; the beat is taken at the first rising
  // edge with stall low, then the payload is held or valid drops for a gap
  task automatic send_req(input req_t r);
    int gap;
    @(negedge clk_i);
    in_valid <= 1'b1;
    in_data  <= r;
    do @(posedge clk_i); while (in_stall);
    gap = pick_gap();
    if (gap > 0) begin
      @(negedge clk_i);
      in_valid <= 1'b0;
      in_data  <= mk_req(2'($urandom_range(0, 3)), rand_block(), $urandom, rand_txn());
      repeat (gap - 1) @(negedge clk_i);
    end
  endtask

  task automatic new_window();
    case ($urandom_range(0, 3))
      0:       win_base = '0;
      1:       win_base = START_MAX - START_W'(4095);
      default: win_base = rand_block();
    endcase
    for (int i = 0; i < 4; i++) txn_pool[i] = rand_txn();
    if ($urandom_range(0, 7) == 0) txn_pool[0] = TXN_MAX;
    if ($urandom_range(0, 7) == 0) txn_pool[1] = '0;
  endtask

  function automatic req_t make_req(burst_kind_e kind);
    req_t r;
    int   pick;
    if (kind == BURST_NOISE) return mk_req(2'($urandom_range(0, 3)), rand_block(), $urandom,
                                          rand_txn());
    pick = $urandom_range(0, 99);
    case (kind)
      BURST_FILL:  r.opcode = (pick < 90) ? OP_LOCK : OP_QUERY;
      BURST_BLEND: r.opcode = (pick < 40) ? OP_LOCK : (pick < 60) ? OP_RELEASE :
                              (pick < 85) ? OP_QUERY : OP_ROLLBACK;
      default:     r.opcode = (pick < 45) ? OP_RELEASE : (pick < 85) ? OP_ROLLBACK : OP_QUERY;
    endcase
    r.range_start = win_base + START_W'($urandom_range(0, 1023));
    pick = $urandom_range(0, 15);
    if (pick == 0) r.range_size = '0;
    else if (pick == 1) r.range_size = $urandom;
    else r.range_size = $urandom_range(1, (r.opcode == OP_LOCK) ? 48 : 600);
    r.txn_id = ($urandom_range(0, 7) == 0) ? rand_txn() : txn_pool[2'($urandom_range(0, 3))];
    return r;
  endfunction

  // receiver side: runs of stall low/high, mostly short, a few long, and
  // occasional long stretches with no stall at all
  initial begin : out_stall_gen
    int r;
    int len;
    logic level;
    out_stall = 1'b0;
    forever begin
      r = $urandom_range(0, 99);
      if (r < 45) begin
        level = 1'b0;
        len   = $urandom_range(1, 8);
      end else if (r < 80) begin
        level = 1'b1;
        len   = $urandom_range(1, 3);
      end else if (r < 90) begin
        level = 1'b1;
        len   = $urandom_range(4, 20);
      end else if (r < 95) begin
        level = 1'b1;
        len   = $urandom_range(40, 120);
      end else begin
        level = 1'b0;
        len   = $urandom_range(200, 400);
      end
      repeat (len) begin
        @(negedge clk_i);
        out_stall <= level;
      end
    end
  end

  initial begin : watchdog
    int idle;
    idle = 0;
    while (idle < IDLE_LIMIT) begin
      @(posedge clk_i);
      if (!rst_ni || (in_valid && !in_stall) || (out_valid && !out_stall)) idle = 0;
      else idle++;
    end
    $display("*** FAILED ***");
    $finish;
  end

  initial begin : stimulus
    int          sent;
    int          len;
    burst_kind_e kind;
    rst_ni   = 1'b0;
    in_valid = 1'b0;
    in_data  = '0;
    repeat (10) @(negedge clk_i);
    rst_ni = 1'b1;

    // directed: empty table, range extremes, empty ranges, overlap rules
    send_req(mk_req(OP_QUERY, '0, '0, '0));
    send_req(mk_req(OP_LOCK, '0, 32'd1, '0));
    send_req(mk_req(OP_LOCK, START_MAX, SIZE_MAX, TXN_MAX));   // end past 48 bits
    send_req(mk_req(OP_LOCK, 48'd5, '0, 31'd1));               // size zero: not stored
    send_req(mk_req(OP_LOCK, 48'd100, 32'd10, 31'd1));
    send_req(mk_req(OP_LOCK, 48'd105, 32'd10, 31'd2));         // overlapping, kept anyway
    send_req(mk_req(OP_QUERY, 48'd110, '0, '0));               // empty range ends at 109
    send_req(mk_req(OP_QUERY, 48'd115, '0, '0));
    send_req(mk_req(OP_QUERY, START_MAX, 32'd1, '0));
    send_req(mk_req(OP_QUERY, START_MAX, SIZE_MAX, TXN_MAX));
    send_req(mk_req(OP_RELEASE, '0, '0, '0));                  // ends at -1: no hit
    send_req(mk_req(OP_RELEASE, 48'd105, '0, '0));             // straddling entry only
    send_req(mk_req(OP_LOCK, 48'd200, 32'd4, 31'd2));          // reuses lowest free slot
    send_req(mk_req(OP_ROLLBACK, '0, '0, 31'd2));
    send_req(mk_req(OP_ROLLBACK, '0, '0, 31'd12345));
    send_req(mk_req(OP_LOCK, 48'h8000_0000_0000, 32'h8000_0000, 31'h4000_0000));
    send_req(mk_req(OP_RELEASE, '0, SIZE_MAX, '0));
    send_req(mk_req(OP_QUERY, 48'h7FFF_FFFF_FFFF, 32'd2, '0));
    send_req(mk_req(OP_RELEASE, 48'h7FFF_FFFF_FFFF, SIZE_MAX, '0));
    send_req(mk_req(OP_ROLLBACK, START_MAX, SIZE_MAX, TXN_MAX));
    send_req(mk_req(OP_ROLLBACK, '0, '0, '0));
    send_req(mk_req(OP_QUERY, '0, SIZE_MAX, '0));

    // random bursts; fill bursts run past the table size to hit table full
    sent = 0;
    while (sent < RANDOM_ITEMS) begin
      case ($urandom_range(0, 9))
        0, 1, 2: begin
          kind = BURST_FILL;
          len  = $urandom_range(20, 75);
        end
        3, 4, 5: begin
          kind = BURST_BLEND;
          len  = $urandom_range(40, 100);
        end
        6, 7, 8: begin
          kind = BURST_DRAIN;
          len  = $urandom_range(5, 30);
        end
        default: begin
          kind = BURST_NOISE;
          len  = $urandom_range(5, 20);
        end
      endcase
      if (len > RANDOM_ITEMS - sent) len = RANDOM_ITEMS - sent;
      new_window();
      repeat (len) begin
        send_req(make_req(kind));
        sent++;
      end
    end
    @(negedge clk_i);
    in_valid <= 1'b0;

    // drain, then give the chain its full latency to show stray beats
    while (pending != 0) @(posedge clk_i);
    repeat (ENTRIES + 16) @(posedge clk_i);
    if (fail_count == 0 && pending == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
